// ===== hw/rtl/whm_pkg.sv =====
// Package with shared types, constants and helpers of the warped history map.
package whm_pkg;
    localparam int MaxWidth   = 512;
    localparam int MaxHeight  = 512;
    localparam int FracBits   = 32;
    localparam int CoefW      = 48;
    localparam int XW         = 9;
    localparam int YW         = 9;
    localparam int AddrW      = XW + YW + 1;
    localparam int DimW       = 10;
    localparam int AccW       = 60;
    localparam int ProdW      = 2 * AccW;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_WARP  = 2'd1;
    localparam logic [1:0] OP_MASK  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DECAY  = 2'd2;

    typedef struct packed {
        logic [1:0]             op;
        logic [2:0]             coef_index;
        logic signed [CoefW-1:0] coef_value;
        logic [XW-1:0]          pixel_x;
        logic [YW-1:0]          pixel_y;
        logic [7:0]             mask_value;
    } t_req;

    typedef struct packed {
        logic [7:0] map_value;
        logic [1:0] op_done;
    } t_rsp;

    function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                                 input logic [DimW-1:0] mx);
        logic [DimW-1:0] r;
        r = v;
        if (v == '0) r = DimW'(1);
        else if (v > mx) r = mx;
        return r;
    endfunction
endpackage

// ===== hw/rtl/whm_stream_if.sv =====
// Valid/ready stream interface carrying one payload.
interface whm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/whm_mul.sv =====
// Multicycle signed multiplier built from 30x30 partial products.
module whm_mul
    import whm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [AccW-1:0]  i_a,
    input  logic signed [AccW-1:0]  i_b,
    output logic                    o_done,
    output logic signed [ProdW-1:0] o_p
);
    localparam int H = AccW / 2;
    logic [AccW-1:0] r_ua, r_ub;
    logic r_neg;
    logic [2:0] r_step, n_step;
    logic [ProdW-1:0] r_acc;
    logic [2*H-1:0] r_pp;
    logic [H-1:0] w_x, w_y;
    logic [6:0] r_sh;

    always_comb begin
        n_step = r_step;
        if (i_start) n_step = 3'd1;
        else if (r_step != 3'd0) n_step = (r_step == 3'd6) ? 3'd0 : r_step + 3'd1;
    end

    always_comb begin
        case (r_step)
            3'd1: begin w_x = r_ua[H-1:0];    w_y = r_ub[H-1:0];    end
            3'd2: begin w_x = r_ua[H-1:0];    w_y = r_ub[AccW-1:H]; end
            3'd3: begin w_x = r_ua[AccW-1:H]; w_y = r_ub[H-1:0];    end
            default: begin w_x = r_ua[AccW-1:H]; w_y = r_ub[AccW-1:H]; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
        end else begin
            r_step <= n_step;
        end
        if (i_start) begin
            r_ua  <= i_a[AccW-1] ? AccW'(-i_a) : AccW'(i_a);
            r_ub  <= i_b[AccW-1] ? AccW'(-i_b) : AccW'(i_b);
            r_neg <= i_a[AccW-1] ^ i_b[AccW-1];
            r_acc <= '0;
        end else if (r_step >= 3'd1 && r_step <= 3'd4) begin
            r_pp <= w_x * w_y;
            r_sh <= (r_step == 3'd1) ? 7'd0 : (r_step == 3'd4) ? 7'(2*H) : 7'(H);
        end
        if (r_step >= 3'd2 && r_step <= 3'd5) begin
            r_acc <= r_acc + (ProdW'(r_pp) << r_sh);
        end else if (r_step == 3'd6 && r_neg) begin
            r_acc <= ProdW'(-r_acc);
        end
    end
    assign o_done = (r_step == 3'd0) && !i_start;
    assign o_p = $signed(r_acc);
endmodule

// ===== hw/rtl/warped_history_map.sv =====
// Top level of the warped history map.
// Channel   Dir  Payload
// s_req     in   op, coef_index, coef_value, pixel_x, pixel_y, mask_value
// m_rsp     out  map_value, op_done
// A load response is valid in the cycle after acceptance, a mask response after the states S_MRD and S_MWR.
// Clear writes zero over the whole map. A warp pass clears the target half, then works
// on each active pixel, with two runs of the shared multiplier.
// Reset is synchronous; the map is cleared by a pass over all of it after reset.
// One request is worked at a time, and a waiting response holds off the next request.
module warped_history_map
    import whm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [DimW-1:0]  i_cfg_data,
    whm_stream_if.sink       s_req,
    whm_stream_if.source     m_rsp
);
    localparam logic [3:0] S_INIT = 4'd0, S_IDLE = 4'd1, S_CLR = 4'd2,
        S_MRD = 4'd3, S_MWR = 4'd4, S_WCLR = 4'd5, S_PIX = 4'd6,
        S_MUL = 4'd7, S_MW = 4'd8, S_PLACE = 4'd9, S_WRD = 4'd10,
        S_WWR = 4'd11, S_OUT = 4'd12, S_ACC = 4'd13;

    logic [7:0] r_mem [0:(1<<AddrW)-1];
    logic [AddrW-1:0] w_addr;
    logic w_we;
    logic [7:0] w_wd, r_rd;

    logic [3:0] r_st;
    logic [AddrW-1:0] r_cnt;
    logic [DimW-1:0] r_fw, r_fh;
    logic [7:0] r_decay;
    logic signed [CoefW-1:0] r_c [0:7];
    logic r_act;
    t_req r_req;
    logic r_ov;
    t_rsp r_rsp;
    logic [DimW-1:0] w_w, w_h;
    logic [XW-1:0] r_i;
    logic [YW-1:0] r_j;
    logic signed [AccW-1:0] r_n, r_ax, r_ay;
    logic [2:0] r_k;
    logic r_second;
    logic [XW-1:0] r_tx;
    logic [YW-1:0] r_ty;
    logic r_hit;
    logic m_start, m_done;
    logic signed [AccW-1:0] m_a, m_b;
    logic signed [ProdW-1:0] m_p;
    logic signed [DimW+1:0] w_ip, w_jp, w_term;
    logic signed [CoefW-1:0] w_cf;
    logic signed [AccW-1:0] w_prod;

    assign w_w = eff_dim(r_fw, DimW'(MaxWidth));
    assign w_h = eff_dim(r_fh, DimW'(MaxHeight));
    assign w_ip = $signed({2'b00, r_i, 1'b0}) - $signed({2'b00, w_w});
    assign w_jp = $signed({2'b00, r_j, 1'b0}) - $signed({2'b00, w_h});
    assign w_cf = r_c[r_k];
    assign w_term = (r_k == 3'd2 || r_k == 3'd5) ? (DimW+2)'(2) :
                    (r_k == 3'd0 || r_k == 3'd3 || r_k == 3'd6) ? w_ip : w_jp;
    assign w_prod = w_cf * w_term;
    assign m_a = r_second ? r_ay : r_ax;
    assign m_b = r_n;
    assign m_start = (r_st == S_MUL);

    whm_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(m_start),
        .i_a(m_a), .i_b(m_b), .o_done(m_done), .o_p(m_p)
    );

    // Place one product: quotient over 2^(2F+1) plus extent, halved.
    function automatic logic [DimW:0] place(input logic signed [ProdW-1:0] p,
                                            input logic [DimW-1:0] e, output logic ok);
        logic signed [ProdW-1:0] q;
        logic signed [ProdW:0] t, lim;
        logic rem;
        q = p >>> (2 * FracBits + 1);
        rem = |p[2*FracBits:0];
        t = $signed({q[ProdW-1], q}) + $signed((ProdW+1)'(e));
        lim = $signed((ProdW+1)'(2 * e)) - 2;
        ok = !(t < 0) && !(t > lim) && !(t == lim && rem);
        return t[DimW+1:1];
    endfunction

    logic [DimW:0] w_pl;
    logic w_ok;
    always_comb w_pl = place(m_p, r_second ? w_h : w_w, w_ok);

    always_comb begin
        w_we = 1'b0;
        w_wd = 8'd0;
        w_addr = r_cnt;
        case (r_st)
            S_INIT, S_CLR: begin w_we = 1'b1; end
            S_MRD: w_addr = {r_act, r_req.pixel_y, r_req.pixel_x};
            S_MWR: begin
                w_addr = {r_act, r_req.pixel_y, r_req.pixel_x};
                w_we = r_ov && (r_req.mask_value != 8'd0);
                w_wd = 8'd255;
            end
            S_WCLR: begin w_addr = {~r_act, r_cnt[AddrW-2:0]}; w_we = 1'b1; end
            S_WRD: w_addr = {r_act, r_j, r_i};
            S_WWR: begin
                w_addr = {~r_act, r_ty, r_tx};
                w_we = r_hit;
                w_wd = (r_rd > r_decay) ? r_rd - r_decay : 8'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_addr] <= w_wd;
        r_rd <= r_mem[w_addr];
    end

    assign s_req.ready = (r_st == S_IDLE);
    assign m_rsp.valid = (r_st == S_OUT);
    assign m_rsp.data = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_cnt <= '0;
            r_fw <= DimW'(512);
            r_fh <= DimW'(512);
            r_decay <= 8'd23;
            r_act <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_c[k] <= (k == 0 || k == 4) ? (CoefW'(1) << FracBits) : '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_fw <= i_cfg_data;
                    CFG_HEIGHT: r_fh <= i_cfg_data;
                    CFG_DECAY:  r_decay <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_st)
                S_INIT, S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt) r_st <= (r_st == S_INIT) ? S_IDLE : S_OUT;
                end
                S_IDLE: if (s_req.valid) begin
                    r_req <= s_req.data;
                    r_rsp.op_done <= s_req.data.op;
                    r_rsp.map_value <= 8'd0;
                    r_cnt <= '0;
                    r_ov <= (DimW'(s_req.data.pixel_x) < w_w) &&
                            (DimW'(s_req.data.pixel_y) < w_h);
                    case (s_req.data.op)
                        OP_LOAD: begin
                            r_c[s_req.data.coef_index] <= s_req.data.coef_value;
                            r_st <= S_OUT;
                        end
                        OP_WARP: r_st <= S_WCLR;
                        OP_MASK: r_st <= S_MRD;
                        default: r_st <= S_CLR;
                    endcase
                end
                S_MRD: r_st <= S_MWR;
                S_MWR: begin
                    if (r_ov) r_rsp.map_value <= (r_req.mask_value != 8'd0) ? 8'd255 : r_rd;
                    r_st <= S_OUT;
                end
                S_WCLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (&r_cnt[AddrW-2:0]) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_st <= S_PIX;
                    end
                end
                S_PIX: begin
                    // Accumulate the three linear forms, one coefficient per cycle.
                    r_n <= AccW'(2) <<< FracBits;
                    r_ax <= '0;
                    r_ay <= '0;
                    r_k <= 3'd0;
                    r_st <= S_ACC;
                end
                S_ACC: begin
                    case (r_k)
                        3'd0, 3'd1, 3'd2: r_ax <= r_ax + w_prod;
                        3'd3, 3'd4, 3'd5: r_ay <= r_ay + w_prod;
                        default: r_n <= r_n + w_prod;
                    endcase
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd7) begin
                        r_second <= 1'b0;
                        r_st <= S_MUL;
                    end
                end
                S_MUL: r_st <= S_MW;
                S_MW: if (m_done) r_st <= S_PLACE;
                S_PLACE: begin
                    if (!r_second) begin
                        r_tx <= w_pl[XW-1:0];
                        r_hit <= w_ok;
                        r_second <= 1'b1;
                        r_st <= S_MUL;
                    end else begin
                        r_ty <= w_pl[YW-1:0];
                        r_hit <= r_hit && w_ok;
                        r_st <= S_WRD;
                    end
                end
                S_WRD: r_st <= S_WWR;
                S_WWR: begin
                    if (DimW'(r_i) == w_w - 1'b1) begin
                        r_i <= '0;
                        if (DimW'(r_j) == w_h - 1'b1) begin
                            r_act <= ~r_act;
                            r_st <= S_OUT;
                        end else begin
                            r_j <= r_j + 1'b1;
                            r_st <= S_PIX;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_st <= S_PIX;
                    end
                end
                S_OUT: if (m_rsp.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !s_req.ready) else $error("ready while busy");
    a_out_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_rsp.valid && m_rsp.ready) |=> (r_st == S_IDLE)) else $error("bad return");
    a_mask_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_rsp.valid && r_rsp.op_done != OP_MASK) |-> (r_rsp.map_value == 8'd0))
        else $error("nonzero value");
`endif
endmodule
